// ----- hdl/art_pkg.sv -----
// ----------------------------------------------------------------------------
// art_pkg
// Types and codes shared by the address region table and its memory.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int ADDR_BITS = 39;
	localparam int FLAG_BITS = 4;
	localparam int COUNT_BITS = 6;

	// item functions
	localparam logic [1:0] FN_LOOKUP = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_RANGE = 2'd1;
	localparam logic [1:0] ST_OVERLAP   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [FLAG_BITS-1:0]  flags_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic [1:0] func;
		addr_t      range_start;
		addr_t      range_end;
		flags_t     region_flags;
		addr_t      lookup_addr;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       hit;
		logic       cache_hit;
		addr_t      hit_start;
		addr_t      hit_end;
		flags_t     hit_flags;
		count_t     region_count;
	} rsp_t;

	// one stored region
	typedef struct packed {
		addr_t  start_addr;
		addr_t  end_addr;
		flags_t flags;
	} region_t;

endpackage

// ----- hdl/address_region_table.sv -----
// ----------------------------------------------------------------------------
// address_region_table
// Sorted table of non-overlapping address regions with lookup, insert, clear.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start high and busy low. busy stays
//   high while the item is worked on. Its single result shows on rsp for one
//   cycle with done high; the receiver must take it then.
//   Per item kind:
//     lookup answered by the last-hit copy, clear, bad range: answered from idle
//     lookup scan: one region read per cycle from the region store, compared
//       in the cycle after its read
//     insert: search up to the sorted place, then shift the tail up one entry
//       per cycle through the same read/write ports
//   A new item may be started in the cycle that done is high.
//   Reset empties the table and the last-hit copy; no clearing pass is needed
//   since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module address_region_table import art_pkg::*; #(
	parameter int MAX_REGIONS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FIND  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] pos_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          have_prev_q;
	addr_t         prev_end_q;
	logic          last_valid_q;
	region_t       last_q;
	req_t          req_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          accept;
	logic          issue_fwd;
	logic          issue_bwd;
	logic [CW-1:0] ptr_dec;
	logic          cache_match;
	logic          lk_hit;
	logic          ins_after;
	logic          prev_ovl;
	logic          next_ovl;
	logic          full;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	region_t       ram_wdata;
	logic [IW-1:0] ram_raddr;
	region_t       ram_rdata;

	function automatic rsp_t mk_rsp(logic [1:0] st, logic h, logic ch, region_t r,
			logic [CW-1:0] n);
		rsp_t o;
		o.status       = st;
		o.hit          = h;
		o.cache_hit    = ch;
		o.hit_start    = r.start_addr;
		o.hit_end      = r.end_addr;
		o.hit_flags    = r.flags;
		o.region_count = count_t'(n);
		return o;
	endfunction

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign issue_fwd = (ptr_q < cnt_q);
	assign issue_bwd = (ptr_q > pos_q);
	assign ptr_dec   = ptr_q - CW'(1);

	assign cache_match = last_valid_q && (last_q.start_addr <= req.lookup_addr)
		&& (req.lookup_addr < last_q.end_addr);
	assign lk_hit    = (ram_rdata.start_addr <= req_q.lookup_addr)
		&& (req_q.lookup_addr < ram_rdata.end_addr);
	assign ins_after = (ram_rdata.start_addr > req_q.range_start);
	assign prev_ovl  = have_prev_q && (prev_end_q > req_q.range_start);
	assign next_ovl  = (req_q.range_end > ram_rdata.start_addr);
	assign full      = (cnt_q == MAX_CNT);

	// read address: forward scan or backward shift
	always_comb begin
		if (state_q == S_SHIFT) begin
			ram_raddr = ptr_dec[IW-1:0];
		end else begin
			ram_raddr = ptr_q[IW-1:0];
		end
	end

	// shift writes entry up by one; the last write places the new region
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1 + IW'(1);
		ram_wdata = ram_rdata;
		if (state_q == S_SHIFT) begin
			if (vld_s1) begin
				ram_we = 1'b1;
			end else if (!issue_bwd) begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IW-1:0];
				ram_wdata = '{start_addr: req_q.range_start, end_addr: req_q.range_end,
					flags: req_q.region_flags};
			end
		end
	end

	art_ram #(
		.DEPTH (MAX_REGIONS),
		.IW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ptr_q        <= '0;
			vld_s1       <= 1'b0;
			have_prev_q  <= 1'b0;
			last_valid_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					vld_s1      <= 1'b0;
					have_prev_q <= 1'b0;
					ptr_q       <= '0;
					if (accept) begin
						req_q <= req;
						case (req.func)
							FN_LOOKUP: begin
								if (cache_match) begin
									done_q <= 1'b1;
									rsp_q  <= mk_rsp(ST_OK, 1'b1, 1'b1, last_q, cnt_q);
								end else if (cnt_q == '0) begin
									done_q <= 1'b1;
									rsp_q  <= mk_rsp(ST_OK, 1'b0, 1'b0, '0, cnt_q);
								end else begin
									state_q <= S_SCAN;
								end
							end
							FN_INSERT: begin
								if (req.range_start >= req.range_end) begin
									done_q <= 1'b1;
									rsp_q  <= mk_rsp(ST_BAD_RANGE, 1'b0, 1'b0, '0, cnt_q);
								end else begin
									state_q <= S_FIND;
								end
							end
							FN_CLEAR: begin
								cnt_q        <= '0;
								last_valid_q <= 1'b0;
								done_q       <= 1'b1;
								rsp_q        <= mk_rsp(ST_OK, 1'b0, 1'b0, '0, '0);
							end
							default: begin
								done_q <= 1'b1;
								rsp_q  <= mk_rsp(ST_OK, 1'b0, 1'b0, '0, cnt_q);
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue_fwd) begin
						ptr_q <= ptr_q + CW'(1);
					end
					vld_s1 <= issue_fwd;
					idx_s1 <= ptr_q[IW-1:0];
					if (vld_s1 && lk_hit) begin
						last_valid_q <= 1'b1;
						last_q       <= ram_rdata;
						done_q       <= 1'b1;
						rsp_q        <= mk_rsp(ST_OK, 1'b1, 1'b0, ram_rdata, cnt_q);
						state_q      <= S_IDLE;
					end else if (!vld_s1 && !issue_fwd) begin
						done_q  <= 1'b1;
						rsp_q   <= mk_rsp(ST_OK, 1'b0, 1'b0, '0, cnt_q);
						state_q <= S_IDLE;
					end
				end
				S_FIND: begin
					if (issue_fwd) begin
						ptr_q <= ptr_q + CW'(1);
					end
					vld_s1 <= issue_fwd;
					idx_s1 <= ptr_q[IW-1:0];
					if (vld_s1 && !ins_after) begin
						prev_end_q  <= ram_rdata.end_addr;
						have_prev_q <= 1'b1;
					end else if (vld_s1 || !issue_fwd) begin
						// sorted place found: first entry above the new start, or the end
						if (prev_ovl || (vld_s1 && next_ovl)) begin
							done_q  <= 1'b1;
							rsp_q   <= mk_rsp(ST_OVERLAP, 1'b0, 1'b0, '0, cnt_q);
							state_q <= S_IDLE;
						end else if (full) begin
							done_q  <= 1'b1;
							rsp_q   <= mk_rsp(ST_FULL, 1'b0, 1'b0, '0, cnt_q);
							state_q <= S_IDLE;
						end else begin
							pos_q   <= vld_s1 ? CW'(idx_s1) : cnt_q;
							ptr_q   <= cnt_q;
							vld_s1  <= 1'b0;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (issue_bwd) begin
						ptr_q <= ptr_dec;
					end
					vld_s1 <= issue_bwd;
					idx_s1 <= ptr_dec[IW-1:0];
					if (!vld_s1 && !issue_bwd) begin
						cnt_q   <= cnt_q + CW'(1);
						done_q  <= 1'b1;
						rsp_q   <= mk_rsp(ST_OK, 1'b0, 1'b0, '0, cnt_q + CW'(1));
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("region count above table size");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result shown while still working");

	a_cache_implies_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.cache_hit) |-> (rsp_q.hit && rsp_q.status == ST_OK))
		else $error("cached answer without hit");

	a_shift_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> !full)
		else $error("shift started on a full table");

	a_item_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done_q || state_q != S_IDLE))
		else $error("accepted item dropped");

endmodule

// ----- hdl/art_ram.sv -----
// ----------------------------------------------------------------------------
// art_ram
// Region store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module art_ram import art_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int IW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  region_t       wdata,
	input  logic [IW-1:0] raddr,
	output region_t       rdata
);

	region_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
